>>> sv/aia_pkg.sv
package aia_pkg;

	// sample and fixed-point formats
	localparam int SAMPLE_WIDTH  = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int FRAC_SHIFT    = 32 - SAMPLE_WIDTH;
	localparam int SQ_W          = 2 * SAMPLE_WIDTH;
	localparam int RAD_W         = SQ_W + 2 * FRAC_SHIFT;
	localparam int ROOT_W        = RAD_W / 2;
	localparam int REM_W         = ROOT_W + 4;
	localparam int CW            = ROOT_W + 3;
	localparam int ACC_W         = 32;
	localparam int ANGLE_W       = 15;
	localparam int ANGLE_LIMIT   = 9000;
	localparam int RUN_STAGES    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

	// control that travels with each request
	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

	// finished result
	typedef struct packed {
		logic signed [ANGLE_W-1:0] tilt;
		logic                      ok;
	} res_t;

	// atan(2^-i) in 1/65536 of a hundredth of a degree
	function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			0:       v = 32'sd294912000;
			1:       v = 32'sd174096719;
			2:       v = 32'sd91987925;
			3:       v = 32'sd46694507;
			4:       v = 32'sd23437865;
			5:       v = 32'sd11730358;
			6:       v = 32'sd5866610;
			7:       v = 32'sd2933484;
			8:       v = 32'sd1466764;
			9:       v = 32'sd733385;
			10:      v = 32'sd366693;
			11:      v = 32'sd183346;
			12:      v = 32'sd91673;
			13:      v = 32'sd45837;
			14:      v = 32'sd22918;
			15:      v = 32'sd11459;
			16:      v = 32'sd5730;
			17:      v = 32'sd2865;
			18:      v = 32'sd1432;
			19:      v = 32'sd716;
			20:      v = 32'sd358;
			21:      v = 32'sd179;
			22:      v = 32'sd90;
			23:      v = 32'sd45;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> sv/aia_if.sv
interface aia_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [aia_pkg::SAMPLE_WIDTH-1:0] accel_x;
	logic signed [aia_pkg::SAMPLE_WIDTH-1:0] accel_y;
	logic signed [aia_pkg::SAMPLE_WIDTH-1:0] accel_z;

	modport source(output valid, accel_x, accel_y, accel_z, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface aia_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [aia_pkg::ANGLE_W-1:0] tilt_angle;
	logic                              angle_valid;

	modport source(output valid, tilt_angle, angle_valid, input ready);
	modport sink(input valid, tilt_angle, angle_valid, output ready);
endinterface

>>> sv/accel_inclination_angle.sv
// Inclination of a three-axis accelerometer sample: atan2(z, sqrt(x*x + y*y)) in hundredths
// of a degree, rounded half up and held to -9000..9000 (+9000 along +z, 0 in the x-y plane).
// An all-zero sample gives angle 0 with angle_valid low. The pipeline takes one sample every
// cycle while sample.ready is high; a result passes through squaring, exact square root at one
// bit per stage, 16 CORDIC rotations, 1 rounding stage and 1 output register. A two-entry
// output queue lets requests keep flowing while a result waits; sample.ready drops only once
// both entries are full, and the whole pipeline holds then.
module accel_inclination_angle (
	input logic      clk,
	input logic      arst_n,
	aia_in_if.sink   sample,
	aia_out_if.source result
);

	logic                                   en;
	logic        [aia_pkg::SQ_W-1:0]         sq;
	logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z_f, z_r;
	aia_pkg::ctl_t                          ctl_f, ctl_r;
	logic        [aia_pkg::ROOT_W-1:0]       root;
	aia_pkg::res_t                          res, out_data;
	logic                                   res_valid;

	assign sample.ready = en;

	// squares of the horizontal axes
	aia_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sample.valid),
		.x        (sample.accel_x),
		.y        (sample.accel_y),
		.z        (sample.accel_z),
		.sq       (sq),
		.z_out    (z_f),
		.ctl      (ctl_f)
	);

	// horizontal magnitude
	aia_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.sq      (sq),
		.z_in    (z_f),
		.ctl_in  (ctl_f),
		.root    (root),
		.z_out   (z_r),
		.ctl_out (ctl_r)
	);

	// arctangent and rounding
	aia_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.root      (root),
		.z         (z_r),
		.ctl_in    (ctl_r),
		.res       (res),
		.res_valid (res_valid)
	);

	// output queue
	aia_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid && en),
		.push_data (res),
		.room      (en),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	assign result.tilt_angle  = out_data.tilt;
	assign result.angle_valid = out_data.ok;

endmodule

>>> sv/aia_front.sv
module aia_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [aia_pkg::SAMPLE_WIDTH-1:0] x,
	input  logic signed [aia_pkg::SAMPLE_WIDTH-1:0] y,
	input  logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z,
	output logic        [aia_pkg::SQ_W-1:0]         sq,
	output logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z_out,
	output aia_pkg::ctl_t                          ctl
);

	logic        [aia_pkg::SAMPLE_WIDTH-1:0] ux_s1, uy_s1;
	logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z_s1, z_s2, z_s3;
	logic        [aia_pkg::SQ_W-1:0]         xx_s2, yy_s2, sq_s3;
	aia_pkg::ctl_t                           ctl_s1, ctl_s2, ctl_s3;

	// control chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.zero  <= (x == '0) && (y == '0) && (z == '0);
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
		end
	end

	// magnitudes, squares, sum
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= x[aia_pkg::SAMPLE_WIDTH-1] ? aia_pkg::SAMPLE_WIDTH'(-x)
			                                    : aia_pkg::SAMPLE_WIDTH'(x);
			uy_s1 <= y[aia_pkg::SAMPLE_WIDTH-1] ? aia_pkg::SAMPLE_WIDTH'(-y)
			                                    : aia_pkg::SAMPLE_WIDTH'(y);
			z_s1  <= z;
			xx_s2 <= aia_pkg::SQ_W'(ux_s1) * aia_pkg::SQ_W'(ux_s1);
			yy_s2 <= aia_pkg::SQ_W'(uy_s1) * aia_pkg::SQ_W'(uy_s1);
			z_s2  <= z_s1;
			sq_s3 <= xx_s2 + yy_s2;
			z_s3  <= z_s2;
		end
	end

	assign sq    = sq_s3;
	assign z_out = z_s3;
	assign ctl   = ctl_s3;

endmodule

>>> sv/aia_isqrt.sv
module aia_isqrt (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic        [aia_pkg::SQ_W-1:0]         sq,
	input  logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z_in,
	input  aia_pkg::ctl_t                          ctl_in,
	output logic        [aia_pkg::ROOT_W-1:0]       root,
	output logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z_out,
	output aia_pkg::ctl_t                          ctl_out
);

	localparam int N = aia_pkg::ROOT_W;

	logic        [aia_pkg::RAD_W-1:0]        rad_s  [N];
	logic        [aia_pkg::REM_W-1:0]        rem_s  [N];
	logic        [aia_pkg::ROOT_W-1:0]       root_s [N];
	logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z_s    [N];
	aia_pkg::ctl_t                           ctl_s  [N];

	// one result bit per stage, two radicand bits consumed
	for (genvar k = 0; k < N; k++) begin : g_step
		logic        [aia_pkg::RAD_W-1:0]        rad_p;
		logic        [aia_pkg::REM_W-1:0]        rem_p, r2, trial;
		logic        [aia_pkg::ROOT_W-1:0]       root_p;
		logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z_p;
		aia_pkg::ctl_t                           ctl_p;

		if (k == 0) begin : g_first
			assign rad_p  = {sq, {(2 * aia_pkg::FRAC_SHIFT){1'b0}}};
			assign rem_p  = '0;
			assign root_p = '0;
			assign z_p    = z_in;
			assign ctl_p  = ctl_in;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign z_p    = z_s[k-1];
			assign ctl_p  = ctl_s[k-1];
		end

		assign r2    = {rem_p[aia_pkg::REM_W-3:0], rad_p[aia_pkg::RAD_W-1 -: 2]};
		assign trial = {{(aia_pkg::REM_W - aia_pkg::ROOT_W - 2){1'b0}}, root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= rad_p << 2;
				z_s[k]   <= z_p;
				if (r2 >= trial) begin
					rem_s[k]  <= r2 - trial;
					root_s[k] <= {root_p[aia_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= r2;
					root_s[k] <= {root_p[aia_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root    = root_s[N-1];
	assign z_out   = z_s[N-1];
	assign ctl_out = ctl_s[N-1];

endmodule

>>> sv/aia_cordic.sv
module aia_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic        [aia_pkg::ROOT_W-1:0]       root,
	input  logic signed [aia_pkg::SAMPLE_WIDTH-1:0] z,
	input  aia_pkg::ctl_t                          ctl_in,
	output aia_pkg::res_t                          res,
	output logic                                   res_valid
);

	localparam int N    = aia_pkg::RUN_STAGES;
	localparam int RQ_W = aia_pkg::ACC_W - 15;
	localparam logic signed [RQ_W-1:0] LIM_P = RQ_W'(aia_pkg::ANGLE_LIMIT);
	localparam logic signed [RQ_W-1:0] LIM_N = RQ_W'(-aia_pkg::ANGLE_LIMIT);
	localparam logic signed [aia_pkg::ACC_W:0] HALF = (aia_pkg::ACC_W + 1)'(32768);

	logic signed [aia_pkg::CW-1:0]    x_in, y_in;
	logic signed [aia_pkg::CW-1:0]    x_s   [N];
	logic signed [aia_pkg::CW-1:0]    y_s   [N];
	logic signed [aia_pkg::ACC_W-1:0] acc_s [N];
	aia_pkg::ctl_t                    ctl_s [N];

	logic signed [aia_pkg::ACC_W:0] rsum;
	logic signed [RQ_W-1:0]         rq;
	aia_pkg::res_t                  res_q;
	logic                           res_valid_q;

	// starting vector (horizontal, vertical)
	assign x_in = $signed({{(aia_pkg::CW - aia_pkg::ROOT_W){1'b0}}, root});
	assign y_in = aia_pkg::CW'(z) <<< aia_pkg::FRAC_SHIFT;

	// vectoring rotations, one per stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [aia_pkg::CW-1:0]    xp, yp;
		logic signed [aia_pkg::ACC_W-1:0] ap;
		aia_pkg::ctl_t                    cp;

		if (i == 0) begin : g_first
			assign xp = x_in;
			assign yp = y_in;
			assign ap = '0;
			assign cp = ctl_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign ap = acc_s[i-1];
			assign cp = ctl_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= cp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yp[aia_pkg::CW-1]) begin
					x_s[i]   <= xp + (yp >>> i);
					y_s[i]   <= yp - (xp >>> i);
					acc_s[i] <= ap + aia_pkg::atan_entry(i);
				end else begin
					x_s[i]   <= xp - (yp >>> i);
					y_s[i]   <= yp + (xp >>> i);
					acc_s[i] <= ap - aia_pkg::atan_entry(i);
				end
			end
		end
	end

	// round half up to hundredths, saturate, give 0 for an all-zero sample
	assign rsum = (aia_pkg::ACC_W + 1)'(acc_s[N-1]) + HALF;
	assign rq   = $signed(rsum[aia_pkg::ACC_W:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= ctl_s[N-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.ok <= !ctl_s[N-1].zero;
			if (ctl_s[N-1].zero) begin
				res_q.tilt <= '0;
			end else if (rq > LIM_P) begin
				res_q.tilt <= LIM_P[aia_pkg::ANGLE_W-1:0];
			end else if (rq < LIM_N) begin
				res_q.tilt <= LIM_N[aia_pkg::ANGLE_W-1:0];
			end else begin
				res_q.tilt <= rq[aia_pkg::ANGLE_W-1:0];
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

>>> sv/aia_obuf.sv
module aia_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  aia_pkg::res_t push_data,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output aia_pkg::res_t out_data
);

	logic          head_v_q, tail_v_q;
	aia_pkg::res_t head_q, tail_q;
	logic          pop;

	assign pop       = head_v_q && out_ready;
	assign room      = !tail_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

	// two-entry output queue, pipeline stalls only when both are full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else if (!head_v_q || pop) begin
			head_v_q <= tail_v_q || push;
			tail_v_q <= tail_v_q && push;
		end else if (push) begin
			tail_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!head_v_q || pop) begin
			head_q <= tail_v_q ? tail_q : push_data;
			if (tail_v_q) begin
				tail_q <= push_data;
			end
		end else if (push) begin
			tail_q <= push_data;
		end
	end

endmodule

>>> sv/aia_checker.sv
module aia_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [aia_pkg::ANGLE_W-1:0] tilt_angle,
	input logic                              angle_valid
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tilt_angle) && $stable(angle_valid))
		else $error("result changed while stalled");

	// zero sample reports zero angle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !angle_valid |-> tilt_angle == '0)
		else $error("invalid angle not zero");

	// angle stays within limits
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tilt_angle >= -15'sd9000) && (tilt_angle <= 15'sd9000))
		else $error("angle out of range");

	// back pressure only with a result waiting
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("request stalled with no result pending");

	// stall clears after a result is taken
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_valid && out_ready |=> in_ready)
		else $error("stall kept after result taken");

endmodule

bind accel_inclination_angle aia_checker u_aia_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.tilt_angle  (result.tilt_angle),
	.angle_valid (result.angle_valid)
);
